// ----- rtl/core/pmd_pkg.sv -----
package pmd_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int HEADER_BYTES         = 20;
  localparam int SEQ_FIRST_BYTE       = 10;
  localparam int COUNT_HI_BYTE        = 18;
  localparam int COUNT_LO_BYTE        = 19;

  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 16;
  localparam int OFFSET_W = 11;
  localparam int SIZE_W   = 16;
  localparam int SEQ_W    = 64;
  localparam int COUNT_W  = 16;
  localparam int VERD_W   = 2;
  localparam int TDATA_W  = 128;

  localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = 16'd64;
  localparam logic [COUNT_W-1:0] COUNT_END       = 16'hFFFF;

  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [VERD_W-1:0] VERD_DATA      = 2'd0;
  localparam logic [VERD_W-1:0] VERD_HEARTBEAT = 2'd1;
  localparam logic [VERD_W-1:0] VERD_END       = 2'd2;
  localparam logic [VERD_W-1:0] VERD_MALFORMED = 2'd3;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                kind;
    logic [INDEX_W-1:0]  msg_index;
    logic [OFFSET_W-1:0] msg_offset;
    logic [SIZE_W-1:0]   payload_len;
    logic [SEQ_W-1:0]    seq_number;
    logic [COUNT_W-1:0]  msg_count;
    logic [VERD_W-1:0]   verdict;
  } result_t;

endpackage

// ----- rtl/core/pmd_parse.sv -----
module pmd_parse import pmd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  input  logic [COUNT_W-1:0] max_count,
  output logic               res_valid,
  output result_t            res
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int OFFW  = (POS_W + 1 > OFFSET_W) ? POS_W + 1 : OFFSET_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic [POS_W-1:0]   pos, pos_next;
  phase_t             phase, phase_next;
  logic [SEQ_W-1:0]   seq_shift, seq_next;
  logic [COUNT_W-1:0] count_reg, count_next;
  logic [INDEX_W-1:0] messages_seen, seen_next;
  logic [SIZE_W-1:0]  bytes_left, left_next;
  logic [BYTE_W-1:0]  length_high, high_next;
  logic               error_flag, err_next;

  logic [OFFW-1:0]    off_wide;
  logic [SIZE_W-1:0]  len_word;
  logic [INDEX_W-1:0] seen_inc;
  logic               have_desc;

  assign off_wide = OFFW'(pos) + OFFW'(1);
  assign len_word = {length_high, in_byte};
  assign seen_inc = messages_seen + INDEX_W'(1);

  always_comb begin
    pos_next   = pos;
    phase_next = phase;
    seq_next   = seq_shift;
    count_next = count_reg;
    seen_next  = messages_seen;
    left_next  = bytes_left;
    high_next  = length_high;
    err_next   = error_flag;
    have_desc  = 1'b0;

    if (pos < POS_MAX) begin
      pos_next = pos + POS_W'(1);
    end else begin
      err_next = 1'b1;
    end

    if (!err_next) begin
      case (phase)
        PH_HEADER: begin
          if (pos >= POS_W'(SEQ_FIRST_BYTE) && pos < POS_W'(COUNT_HI_BYTE)) begin
            seq_next = {seq_shift[SEQ_W-BYTE_W-1:0], in_byte};
          end else if (pos == POS_W'(COUNT_HI_BYTE)) begin
            count_next = {in_byte, {BYTE_W{1'b0}}};
          end else if (pos == POS_W'(COUNT_LO_BYTE)) begin
            count_next = count_reg | COUNT_W'(in_byte);
          end
          if (pos == POS_W'(HEADER_BYTES - 1)) begin
            if (count_next == '0 || count_next == COUNT_END) begin
              phase_next = PH_DONE;
            end else if (count_next > max_count) begin
              err_next = 1'b1;
            end else begin
              phase_next = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          high_next  = in_byte;
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          left_next = len_word;
          if (len_word == '0) begin
            err_next = 1'b1;
          end else begin
            have_desc  = 1'b1;
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_next = bytes_left - SIZE_W'(1);
          if (left_next == '0) begin
            seen_next  = seen_inc;
            phase_next = (seen_inc == count_reg) ? PH_DONE : PH_LEN_HI;
          end
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  // verdict on the last word takes priority over a descriptor in the same word
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (in_last) begin
      res_valid      = 1'b1;
      res.kind       = KIND_VERDICT;
      res.seq_number = seq_next;
      res.msg_count  = count_next;
      if (err_next || phase_next != PH_DONE) begin
        res.verdict = VERD_MALFORMED;
      end else if (count_next == '0) begin
        res.verdict = VERD_HEARTBEAT;
      end else if (count_next == COUNT_END) begin
        res.verdict = VERD_END;
      end else begin
        res.verdict = VERD_DATA;
      end
    end else if (have_desc) begin
      res_valid       = 1'b1;
      res.kind        = KIND_DESC;
      res.msg_index   = messages_seen;
      res.msg_offset  = off_wide[OFFSET_W-1:0];
      res.payload_len = len_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      pos           <= '0;
      phase         <= PH_HEADER;
      seq_shift     <= '0;
      count_reg     <= '0;
      messages_seen <= '0;
      bytes_left    <= '0;
      length_high   <= '0;
      error_flag    <= 1'b0;
    end else if (step) begin
      pos           <= pos_next;
      phase         <= phase_next;
      seq_shift     <= seq_next;
      count_reg     <= count_next;
      messages_seen <= seen_next;
      bytes_left    <= left_next;
      length_high   <= high_next;
      error_flag    <= err_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_MAX) else $error("byte position beyond packet limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> pos == '0 && phase == PH_HEADER && !error_flag)
    else $error("packet state not cleared after last word");

  a_no_desc_after_err: assert property (@(posedge clk) disable iff (rst)
    error_flag && !in_last |-> !res_valid)
    else $error("result emitted after packet error");

  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    !error_flag |-> messages_seen <= count_reg)
    else $error("more messages seen than announced");

  a_desc_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_DESC |-> res.payload_len != '0)
    else $error("descriptor with zero size");

endmodule

// ----- rtl/core/packet_message_deframer.sv -----
// A word accepted on s_axis passes the input register, then the result register, to
// reach m_axis; words that cause no result give none.
// Throughput: one byte per cycle sustained while m_axis_tready stays high, set by the
// single-pass parse logic between the input and result registers.
// Reset (rst, synchronous): clears packet state and both stages; max_message_count
// returns to 64.
module packet_message_deframer import pmd_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic               s_axis_tlast,  // last_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] msg_index, [26:16] msg_offset, [42:27] payload_len, [106:43] seq_number,
  // [122:107] msg_count, [124:123] verdict, [127:125] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tuser,  // [0] kind
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data       // max_message_count
);

  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               in_last;
  logic               out_valid;
  result_t            out_res;
  logic [COUNT_W-1:0] max_count;
  logic               step;
  logic               res_valid;
  result_t            res;

  // a word moves on whenever the result register is free or being drained
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (cfg_valid) begin
      max_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  pmd_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .max_count (max_count),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {3'b000, out_res.verdict, out_res.msg_count, out_res.seq_number,
                          out_res.payload_len, out_res.msg_offset, out_res.msg_index};

endmodule
